[rtl/tgcs_pkg.sv]
// types and constants shared by the text grid files
`timescale 1ns / 1ps

package tgcs_pkg;

    localparam int CHAR_W  = 8;
    localparam int ACT_W   = 3;
    localparam int IN_ATTR_W = 8;
    localparam int IN_COL_W  = 7;
    localparam int IN_ROW_W  = 5;
    localparam int REG_W   = 5;

    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
    localparam logic [REG_W-1:0]  BOTTOM_ROW_RESET = 5'd23;

    localparam logic [ACT_W-1:0] ACT_PUT_CURSOR  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUT_CELL    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_CR          = 3'd2;
    localparam logic [ACT_W-1:0] ACT_LF          = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SCROLL_UP   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_SCROLL_DOWN = 3'd5;
    localparam logic [ACT_W-1:0] ACT_READ        = 3'd6;

    localparam logic REG_REGION_TOP    = 1'b0;
    localparam logic REG_REGION_BOTTOM = 1'b1;

    typedef struct packed {
        logic [ACT_W-1:0]     action;
        logic [CHAR_W-1:0]    char_code;
        logic [IN_ATTR_W-1:0] attr_code;
        logic [IN_COL_W-1:0]  col;
        logic [IN_ROW_W-1:0]  row;
    } in_item_t;

    typedef struct packed {
        logic [IN_COL_W-1:0]  cursor_col;
        logic [IN_ROW_W-1:0]  cursor_row;
        logic [CHAR_W-1:0]    cell_char;
        logic [IN_ATTR_W-1:0] cell_attr;
        logic                 cell_dirty;
    } out_item_t;

endpackage

[rtl/tgcs_stream_if.sv]
// valid/ready stream channel with a typed payload
`timescale 1ns / 1ps

interface tgcs_stream_if #(parameter type data_t = logic);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/text_grid_cursor_scroll.sv]
// text grid top level: sequencer, cursor, region registers and result register
//
//  channel  dir  handshake          payload
//  cmd      in   valid/ready        action, char_code, attr_code, col, row
//  res      out  valid/ready        cursor_col, cursor_row, cell_char, cell_attr, cell_dirty
//  apb      in   psel/penable       region_top_row at 0x0, region_bottom_row at 0x4
//
// carriage return, line feed without scroll: straight to done; put: a write state; read: issue, then writeback
// scroll: a read and a write per region cell, then one row blanked; one memory port pair
// after reset a clearing pass blanks every cell of the grid before cmd is ready
// cmd is ready only between items; a finished result waits in res until taken
`timescale 1ns / 1ps

module text_grid_cursor_scroll import tgcs_pkg::*; #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 24,
    parameter int ATTR_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    tgcs_stream_if.sink   cmd,
    tgcs_stream_if.source res
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    localparam logic [ADDR_W-1:0] STRIDE    = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);

    typedef struct packed {
        logic                 dirty;
        logic [ATTR_BITS-1:0] attr;
        logic [CHAR_W-1:0]    chr;
    } cell_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_PUT_WR,
        S_RD_ISSUE,
        S_RD_WB,
        S_SU_SETUP,
        S_SU_SETUP2,
        S_SD_SETUP,
        S_SD_SETUP2,
        S_COPY_RD,
        S_COPY_WR,
        S_BLANK,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic [ACT_W-1:0]     act_reg;
    logic [CHAR_W-1:0]    ch_reg;
    logic [ATTR_BITS-1:0] at_reg;
    logic [IN_COL_W-1:0]  x_reg;
    logic [IN_ROW_W-1:0]  y_reg;
    logic [COL_W-1:0]     cur_col_reg;
    logic [ROW_W-1:0]     cur_row_reg;
    logic [ADDR_W-1:0]    ptr_reg;
    logic [ADDR_W-1:0]    base_reg;
    logic [COL_W-1:0]     cnt_reg;
    logic                 down_reg;
    logic                 cell_ok_reg;
    logic [CHAR_W-1:0]    rc_reg;
    logic [IN_ATTR_W-1:0] ra_reg;
    logic                 rd_reg;
    logic                 res_valid_reg;
    out_item_t            res_data_reg;
    logic [REG_W-1:0]     top_reg;
    logic [REG_W-1:0]     bot_reg;

    logic [ROW_W-1:0]  top_c;
    logic [ROW_W-1:0]  bot_c;
    logic              lf_scroll;
    logic              in_range;
    logic [ROW_W-1:0]  agu_row;
    logic [COL_W-1:0]  agu_col;
    logic [ADDR_W-1:0] agu_addr;
    logic [ADDR_W-1:0] src_addr;
    logic              mem_we;
    cell_t             mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [$bits(cell_t)-1:0] mem_rdata_raw;
    cell_t             mem_rdata;

    // region registers
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
            bot_reg <= BOTTOM_ROW_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_REGION_TOP:    top_reg <= pwdata[REG_W-1:0];
                REG_REGION_BOTTOM: bot_reg <= pwdata[REG_W-1:0];
                default:           top_reg <= top_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_REGION_TOP:    prdata = 32'(top_reg);
            REG_REGION_BOTTOM: prdata = 32'(bot_reg);
            default:           prdata = '0;
        endcase
    end

    // clamped region and cursor tests
    assign top_c = (int'(top_reg) >= ROWS) ? ROW_LAST : ROW_W'(top_reg);
    assign bot_c = (int'(bot_reg) >= ROWS) ? ROW_LAST : ROW_W'(bot_reg);
    assign lf_scroll = ({1'b0, cur_row_reg} + 1'b1) > {1'b0, bot_c};
    assign in_range  = (int'(x_reg) < COLUMNS) && (int'(y_reg) < ROWS);

    // address unit operands
    always_comb
    begin
        agu_row = cur_row_reg;
        agu_col = cur_col_reg;
        unique case (state_reg)
            S_DISPATCH:
            begin
                if (act_reg != ACT_PUT_CURSOR)
                begin
                    agu_row = ROW_W'(y_reg);
                    agu_col = COL_W'(x_reg);
                end
            end
            S_SU_SETUP:
            begin
                agu_row = top_c;
                agu_col = '0;
            end
            S_SU_SETUP2:
            begin
                agu_row = bot_c;
                agu_col = '0;
            end
            S_SD_SETUP:
            begin
                agu_row = bot_c;
                agu_col = COL_LAST;
            end
            S_SD_SETUP2:
            begin
                agu_row = top_c;
                agu_col = '0;
            end
            default:
            begin
                agu_row = cur_row_reg;
                agu_col = cur_col_reg;
            end
        endcase
    end

    tgcs_agu #(
        .COLUMNS (COLUMNS),
        .ROW_W   (ROW_W),
        .COL_W   (COL_W),
        .ADDR_W  (ADDR_W)
    ) u_agu (
        .row  (agu_row),
        .col  (agu_col),
        .addr (agu_addr)
    );

    // memory port control
    assign src_addr  = down_reg ? (ptr_reg - STRIDE) : (ptr_reg + STRIDE);
    assign mem_re    = (state_reg == S_COPY_RD) || (state_reg == S_RD_ISSUE);
    assign mem_raddr = (state_reg == S_COPY_RD) ? src_addr : ptr_reg;
    assign mem_rdata = cell_t'(mem_rdata_raw);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = '{dirty: 1'b1, attr: '0, chr: BLANK_CHAR};
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '{dirty: 1'b0, attr: '0, chr: BLANK_CHAR};
            end
            S_PUT_WR:
            begin
                mem_we    = cell_ok_reg;
                mem_wdata = '{dirty: 1'b1, attr: at_reg, chr: ch_reg};
            end
            S_COPY_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '{dirty: 1'b1, attr: mem_rdata.attr, chr: mem_rdata.chr};
            end
            S_BLANK:
            begin
                mem_we    = 1'b1;
                mem_wdata = '{dirty: 1'b1, attr: '0, chr: BLANK_CHAR};
            end
            S_RD_WB:
            begin
                mem_we    = 1'b1;
                mem_wdata = '{dirty: 1'b0, attr: mem_rdata.attr, chr: mem_rdata.chr};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    tgcs_cell_mem #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W),
        .DATA_W ($bits(cell_t))
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (ptr_reg),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata_raw)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            act_reg       <= '0;
            ch_reg        <= '0;
            at_reg        <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            ptr_reg       <= '0;
            base_reg      <= '0;
            cnt_reg       <= '0;
            down_reg      <= 1'b0;
            cell_ok_reg   <= 1'b0;
            rc_reg        <= '0;
            ra_reg        <= '0;
            rd_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
            res_data_reg  <= '0;
        end
        else
        begin
            if (res_valid_reg && res.ready && (state_reg != S_DONE))
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (ptr_reg == LAST_ADDR)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        act_reg   <= cmd.data.action;
                        ch_reg    <= cmd.data.char_code;
                        at_reg    <= ATTR_BITS'(cmd.data.attr_code);
                        x_reg     <= cmd.data.col;
                        y_reg     <= cmd.data.row;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    rc_reg  <= '0;
                    ra_reg  <= '0;
                    rd_reg  <= 1'b0;
                    ptr_reg <= agu_addr;
                    unique case (act_reg)
                        ACT_PUT_CURSOR:
                        begin
                            cell_ok_reg <= 1'b1;
                            state_reg   <= S_PUT_WR;
                        end
                        ACT_PUT_CELL:
                        begin
                            cell_ok_reg <= in_range;
                            state_reg   <= S_PUT_WR;
                        end
                        ACT_CR:
                        begin
                            cur_col_reg <= '0;
                            state_reg   <= S_DONE;
                        end
                        ACT_LF:
                        begin
                            if (lf_scroll)
                            begin
                                state_reg <= S_SU_SETUP;
                            end
                            else
                            begin
                                cur_row_reg <= cur_row_reg + 1'b1;
                                state_reg   <= S_DONE;
                            end
                        end
                        ACT_SCROLL_UP:   state_reg <= S_SU_SETUP;
                        ACT_SCROLL_DOWN: state_reg <= S_SD_SETUP;
                        ACT_READ:        state_reg <= in_range ? S_RD_ISSUE : S_DONE;
                        default:         state_reg <= S_DONE;
                    endcase
                end
                S_PUT_WR:
                begin
                    state_reg <= S_DONE;
                    if (act_reg == ACT_PUT_CURSOR)
                    begin
                        if (cur_col_reg == COL_LAST)
                        begin
                            cur_col_reg <= '0;
                            if (lf_scroll)
                            begin
                                state_reg <= S_SU_SETUP;
                            end
                            else
                            begin
                                cur_row_reg <= cur_row_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            cur_col_reg <= cur_col_reg + 1'b1;
                        end
                    end
                end
                S_RD_ISSUE:
                begin
                    state_reg <= S_RD_WB;
                end
                S_RD_WB:
                begin
                    rc_reg    <= mem_rdata.chr;
                    ra_reg    <= IN_ATTR_W'(mem_rdata.attr);
                    rd_reg    <= mem_rdata.dirty;
                    state_reg <= S_DONE;
                end
                S_SU_SETUP:
                begin
                    down_reg  <= 1'b0;
                    ptr_reg   <= agu_addr;
                    state_reg <= S_SU_SETUP2;
                end
                S_SU_SETUP2:
                begin
                    base_reg <= agu_addr;
                    cnt_reg  <= '0;
                    if (bot_c > top_c)
                    begin
                        state_reg <= S_COPY_RD;
                    end
                    else
                    begin
                        ptr_reg   <= agu_addr;
                        state_reg <= S_BLANK;
                    end
                end
                S_SD_SETUP:
                begin
                    down_reg  <= 1'b1;
                    ptr_reg   <= agu_addr;
                    state_reg <= S_SD_SETUP2;
                end
                S_SD_SETUP2:
                begin
                    base_reg <= agu_addr;
                    cnt_reg  <= '0;
                    if (bot_c > top_c)
                    begin
                        state_reg <= S_COPY_RD;
                    end
                    else
                    begin
                        ptr_reg   <= agu_addr;
                        state_reg <= S_BLANK;
                    end
                end
                S_COPY_RD:
                begin
                    state_reg <= S_COPY_WR;
                end
                S_COPY_WR:
                begin
                    if (down_reg)
                    begin
                        if (ptr_reg == (base_reg + STRIDE))
                        begin
                            ptr_reg   <= base_reg;
                            state_reg <= S_BLANK;
                        end
                        else
                        begin
                            ptr_reg   <= ptr_reg - 1'b1;
                            state_reg <= S_COPY_RD;
                        end
                    end
                    else
                    begin
                        if ((ptr_reg + 1'b1) == base_reg)
                        begin
                            ptr_reg   <= base_reg;
                            state_reg <= S_BLANK;
                        end
                        else
                        begin
                            ptr_reg   <= ptr_reg + 1'b1;
                            state_reg <= S_COPY_RD;
                        end
                    end
                end
                S_BLANK:
                begin
                    if (cnt_reg == COL_LAST)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (!res_valid_reg || res.ready)
                    begin
                        res_valid_reg           <= 1'b1;
                        res_data_reg.cursor_col <= IN_COL_W'(cur_col_reg);
                        res_data_reg.cursor_row <= IN_ROW_W'(cur_row_reg);
                        res_data_reg.cell_char  <= rc_reg;
                        res_data_reg.cell_attr  <= ra_reg;
                        res_data_reg.cell_dirty <= rd_reg;
                        state_reg               <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/tgcs_cell_mem.sv]
// cell memory, one write port and one registered read port
`timescale 1ns / 1ps

module tgcs_cell_mem #(
    parameter int DEPTH  = 1920,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 17
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_array [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/tgcs_agu.sv]
// address unit, linear cell address from row and column
`timescale 1ns / 1ps

module tgcs_agu #(
    parameter int COLUMNS = 80,
    parameter int ROW_W   = 5,
    parameter int COL_W   = 7,
    parameter int ADDR_W  = 11
) (
    input  logic [ROW_W-1:0]  row,
    input  logic [COL_W-1:0]  col,
    output logic [ADDR_W-1:0] addr
);

    localparam logic [ADDR_W-1:0] STRIDE = ADDR_W'(COLUMNS);

    assign addr = ADDR_W'(ADDR_W'(row) * STRIDE) + ADDR_W'(col);

endmodule
